// File: hw/rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// shared widths and defaults for the pair sum search block
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int DEFAULT_STORE_DEPTH = 256;
  localparam int DATA_W              = 32;
  localparam int SUM_W               = DATA_W + 1;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

// File: hw/rtl/pair_sum_exists.sv
// ----------------------------------------------------------------------------
// pair_sum_exists
// loads a set of signed entries, merge sorts them between two memories and
// walks the sorted set from both ends to find two entries summing to target
//
//   channel   dir  signals                     content
//   s_axis    in   tvalid tready tdata tlast   element_value, is_last
//   m_axis    out  tvalid tready tdata         pair_found, overflowed
//   cfg       in   cfg_we cfg_wdata            target_sum
//
// loading takes one beat per cycle; sorting starts after the tlast beat
// sort: ceil(log2 n) merge passes, bound by the single read port of the
// source memory (each entry is merged in ST_MRG, then reloaded in ST_RLD)
// pair walk: ST_CMP and ST_RLDS alternate; ST_DONE presents the result beat
// s_axis_tready is low after the tlast beat until the result is registered;
// a waiting result does not block loading of the next set
// rst clears control state only, no memory clearing pass
// ----------------------------------------------------------------------------
module pair_sum_exists
  import pse_pkg::*;
#(
  parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata,      // target_sum
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // element_value
  input  logic              s_axis_tlast,   // is_last
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata    // [0] pair_found, [1] overflowed
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = AW + 1;   // holds the entry count itself
  localparam int XW = CW + 1;   // run bounds up to twice the count

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_RUN   = 4'd1;
  localparam logic [3:0] ST_RUN_A = 4'd2;
  localparam logic [3:0] ST_RUN_B = 4'd3;
  localparam logic [3:0] ST_MRG   = 4'd4;
  localparam logic [3:0] ST_RLD   = 4'd5;
  localparam logic [3:0] ST_SRCH  = 4'd6;
  localparam logic [3:0] ST_SL0   = 4'd7;
  localparam logic [3:0] ST_SH0   = 4'd8;
  localparam logic [3:0] ST_CMP   = 4'd9;
  localparam logic [3:0] ST_RLDS  = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  elem_t mem0 [STORE_DEPTH];
  elem_t mem1 [STORE_DEPTH];
  elem_t rd0, rd1, rdv;

  logic [3:0]    state;
  logic [AW-1:0] rd_addr;
  logic          wr_en, wr_sel;
  logic [AW-1:0] wr_addr;
  elem_t         wr_data;

  elem_t         target;
  logic [CW-1:0] count, n_set;
  logic          dropped, ovf;
  logic          src;
  logic [XW-1:0] w, l, m, e, i, j, k;
  elem_t         av, bv;
  logic          reload_a;
  logic [XW-1:0] lo, hi;
  logic          found;
  logic          out_pf, out_ovf;

  logic [XW-1:0] l_w, l_2w, m_c, e_c, n_x;
  logic          a_ok, b_ok, take_a;
  sum_t          pair_sum, tgt_x;
  logic          accept;

  assign n_x  = XW'(n_set);
  assign l_w  = l + w;
  assign l_2w = l + (w << 1);
  assign m_c  = (l_w < n_x) ? l_w : n_x;
  assign e_c  = (l_2w < n_x) ? l_2w : n_x;
  assign a_ok = (i < m);
  assign b_ok = (j < e);
  assign take_a = a_ok && (!b_ok || (av <= bv));
  assign pair_sum = sum_t'(av) + sum_t'(bv);
  assign tgt_x    = sum_t'(target);

  assign s_axis_tready = (state == ST_LOAD);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rdv           = src ? rd1 : rd0;
  assign m_axis_tdata  = {6'b0, out_ovf, out_pf};

  // read address goes out in the cycle before its data is taken
  always_comb begin
    rd_addr = '0;
    unique case (state)
      ST_RUN:   rd_addr = l[AW-1:0];
      ST_RUN_A: rd_addr = j[AW-1:0];
      ST_MRG:   rd_addr = take_a ? i[AW-1:0] + 1'b1 : j[AW-1:0] + 1'b1;
      ST_SL0:   rd_addr = hi[AW-1:0];
      ST_CMP:   rd_addr = (pair_sum < tgt_x) ? lo[AW-1:0] + 1'b1 : hi[AW-1:0] - 1'b1;
      default:  rd_addr = '0;
    endcase
  end

  // write port: loading goes to mem0, merges go to the destination side
  always_comb begin
    wr_en   = 1'b0;
    wr_sel  = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = elem_t'(s_axis_tdata);
    if (accept && (count < CW'(STORE_DEPTH))) begin
      wr_en = 1'b1;
    end else if (state == ST_MRG) begin
      wr_en   = 1'b1;
      wr_sel  = ~src;
      wr_addr = k[AW-1:0];
      wr_data = take_a ? av : bv;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_sel) mem0[wr_addr] <= wr_data;
    if (wr_en && wr_sel)  mem1[wr_addr] <= wr_data;
    rd0 <= mem0[rd_addr];
    rd1 <= mem1[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      target        <= '0;
      count         <= '0;
      dropped       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      src           <= 1'b0;
    end else begin
      if (cfg_we) target <= elem_t'(cfg_wdata);
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) m_axis_tvalid <= 1'b0;

      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (s_axis_tlast) begin
              n_set   <= (count < CW'(STORE_DEPTH)) ? count + 1'b1 : count;
              ovf     <= dropped || (count == CW'(STORE_DEPTH));
              count   <= '0;
              dropped <= 1'b0;
              src     <= 1'b0;
              w       <= XW'(1);
              l       <= '0;
              found   <= 1'b0;
              if (count == '0) state <= ST_DONE;   // single entry, no pair
              else state <= ST_RUN;
            end else if (count < CW'(STORE_DEPTH)) begin
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        ST_RUN: begin
          m     <= m_c;
          e     <= e_c;
          i     <= l;
          j     <= m_c;
          k     <= l;
          state <= ST_RUN_A;
        end
        ST_RUN_A: begin
          av    <= rdv;
          state <= ST_RUN_B;
        end
        ST_RUN_B: begin
          bv    <= rdv;
          state <= ST_MRG;
        end
        ST_MRG: begin
          k        <= k + 1'b1;
          reload_a <= take_a;
          if (take_a) begin
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
          if (k + 1'b1 == e) begin
            // run finished: next run, next pass, or search
            if (l_2w >= n_x) begin
              l   <= '0;
              w   <= w << 1;
              src <= ~src;
              if ((w << 1) >= n_x) state <= ST_SRCH;
              else state <= ST_RUN;
            end else begin
              l     <= l_2w;
              state <= ST_RUN;
            end
          end else begin
            state <= ST_RLD;
          end
        end
        ST_RLD: begin
          if (reload_a) av <= rdv;
          else bv <= rdv;
          state <= ST_MRG;
        end
        ST_SRCH: begin
          lo    <= '0;
          hi    <= n_x - 1'b1;
          state <= ST_SL0;
        end
        ST_SL0: begin
          av    <= rdv;
          state <= ST_SH0;
        end
        ST_SH0: begin
          bv    <= rdv;
          state <= ST_CMP;
        end
        ST_CMP: begin
          // av is the low end, bv the high end of the sorted set
          priority if (lo >= hi) begin
            state <= ST_DONE;
          end else if (pair_sum == tgt_x) begin
            found <= 1'b1;
            state <= ST_DONE;
          end else if (pair_sum < tgt_x) begin
            lo       <= lo + 1'b1;
            reload_a <= 1'b1;
            state    <= ST_RLDS;
          end else begin
            hi       <= hi - 1'b1;
            reload_a <= 1'b0;
            state    <= ST_RLDS;
          end
        end
        ST_RLDS: begin
          if (reload_a) av <= rdv;
          else bv <= rdv;
          state <= ST_CMP;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_pf        <= found;
            out_ovf       <= ovf;
            state         <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_only_loading: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == ST_LOAD)) else $error("ready outside load");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STORE_DEPTH)) else $error("entry count beyond store depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (hi < n_x)) else $error("pair walk beyond set");

  a_merge_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MRG) |-> (k < e) && (a_ok || b_ok))
    else $error("merge write outside its run");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks pair_sum_exists: sets of signed entries are streamed in, each set
// closed by tlast; a scoreboard predicts the found and overflow bits of every
// set and compares them with the result beats, under random idling on both
// sides and several target settings
// ----------------------------------------------------------------------------
module tb;
  import pse_pkg::*;

  localparam int DEPTH     = DEFAULT_STORE_DEPTH;
  localparam int MAX_QUIET = 200000;

  class pair_scoreboard;
    elem_t      target;
    elem_t      entries[$];
    bit         dropped;
    bit [1:0]   pending[$];   // {overflowed, pair_found}
    int         errors;

    function bit has_pair();
      for (int i = 0; i < entries.size(); i++)
        for (int j = i + 1; j < entries.size(); j++)
          if (sum_t'(entries[i]) + sum_t'(entries[j]) == sum_t'(target)) return 1'b1;
      return 1'b0;
    endfunction

    function void note_entry(elem_t v, bit last);
      if (entries.size() < DEPTH) entries.push_back(v);
      else dropped = 1'b1;
      if (last) begin
        pending.push_back({dropped, has_pair()});
        entries.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(logic [7:0] d);
      bit [1:0] e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: result beat %h with nothing expected", d);
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e[0] || d[1] !== e[1]) begin
        errors++;
        if (errors <= 10)
          $display("tb: mismatch found exp %0b got %0b, overflowed exp %0b got %0b",
                   e[0], d[0], e[1], d[1]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;    // [31:0] element_value
  logic        s_axis_tlast;    // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;    // [0] pair_found, [1] overflowed

  pair_scoreboard sb;
  int  tx_idle_pct;
  int  rx_stall_pct;
  int  quiet_cycles;
  int  items_sent;

  pair_sum_exists #(.STORE_DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: check accepted beats, stall at random
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= MAX_QUIET) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_beat(elem_t v, bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_entry(v, last);
    items_sent++;
  endtask

  task automatic send_list(elem_t vals[$]);
    for (int i = 0; i < vals.size(); i++) send_beat(vals[i], i == vals.size() - 1);
  endtask

  // close the stream and let the search finish before touching the target
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_target(elem_t t);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.target = t;
  endtask

  function automatic elem_t pick_value();
    int sel;
    sel = $urandom_range(7);
    if (sel >= 3 && sel <= 4 && sb.entries.size() != 0)
      return sb.target - sb.entries[$urandom_range(sb.entries.size() - 1)];
    case (sel)
      5: return $signed($urandom_range(8)) - 4;
      6: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      7: return sb.target >>> 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_set();
    int n;
    if ($urandom_range(59) == 0) n = $urandom_range(DEPTH + 6, DEPTH - 6);
    else n = $urandom_range(12, 1);
    for (int i = 0; i < n; i++) send_beat(pick_value(), i == n - 1);
  endtask

  initial begin
    elem_t big[$];
    sb = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    items_sent    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single entry, opposite pair, equal entries, extremes
    set_target(32'sd0);
    send_list('{32'sd5});
    send_list('{32'sd7, -32'sd7});
    send_list('{32'sd0, 32'sd0});
    send_list('{32'h80000000, 32'sd1});
    set_target(-32'sd1);
    send_list('{32'h80000000, 32'h7fffffff});
    send_list('{-32'sd1});
    // complement of -1 lies above the 32-bit range
    set_target(32'h7fffffff);
    send_list('{-32'sd1, 32'sd2});
    send_list('{32'h7fffffff, 32'sd0});
    set_target(32'h80000000);
    send_list('{32'sd1, 32'h80000000, -32'sd1});
    send_list('{32'h80000000, 32'sd0});
    set_target(32'sd6);
    send_list('{32'sd3, 32'sd3});
    send_list('{32'sd3, 32'sd4});
    // store full, final beat dropped as well
    set_target(32'sd0);
    for (int i = 1; i <= DEPTH + 2; i++) big.push_back(i);
    send_list(big);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      case (ph)
        0: set_target(32'sd0);
        1: set_target(-32'sd1);
        2: set_target(32'h7fffffff);
        default: set_target($urandom);
      endcase
      while (items_sent < 300 + 250 * (ph + 1)) send_random_set();
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pse_pkg.sv
hw/rtl/pair_sum_exists.sv
sim/tb.sv
